// ----- rtl/qgem_pkg.sv -----
`default_nettype none
package qgem_pkg;

	localparam int WIDTH_BITS  = 8;
	localparam int HEIGHT_BITS = 13;
	localparam int LEVEL_BITS  = 3;
	localparam int ADDR_BITS   = 4;
	localparam int DATA_BITS   = 32;

	localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 8'd80;
	localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 13'd100;
	localparam logic [LEVEL_BITS-1:0]  LEVEL_RESET  = 3'd4;

	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_LEVELS = 2'd2,
		REG_NONE   = 2'd3
	} reg_index_t;

	localparam logic [LEVEL_BITS-1:0] LEVELS_2 = 3'd2;
	localparam logic [LEVEL_BITS-1:0] LEVELS_3 = 3'd3;
	localparam logic [LEVEL_BITS-1:0] LEVELS_4 = 3'd4;

	localparam logic [7:0] SYM_SPACE = 8'h20;
	localparam logic [7:0] SYM_HASH  = 8'h23;
	localparam logic [7:0] SYM_DOT   = 8'h2E;
	localparam logic [7:0] SYM_COLON = 8'h3A;
	localparam logic [7:0] SYM_NONE  = 8'h00;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS   = 1;
	localparam int QCNT_BITS   = 2;

	typedef struct packed {
		logic [1:0] p1;
		logic [1:0] p2;
		logic [1:0] p3;
		logic [1:0] p4;
		logic       row_end;
		logic       image_end;
	} window_t;

endpackage
`default_nettype wire

// ----- rtl/quad_gradient_edge_map_unit.sv -----
`default_nettype none
// Edge map of a raster image of 2-bit grey pixels. Pixels are pushed in raster order; every
// pixel that completes a 2x2 window (not first row, not first column) yields one item with the
// largest of four gradients, an ASCII symbol chosen by the level count, and row/image end
// flags. One pixel per clock is taken while full is low; the line store is a single-port
// read-first memory touched once per pixel. Width, height and level count are set over the APB
// port at byte addresses 0, 4 and 8; the user must write them only while the block is idle,
// which the block does not enforce; width is clamped to 1..LINE_LENGTH and height to 1..ROW_LIMIT.
module quad_gradient_edge_map_unit #(
	parameter int LINE_LENGTH = 128,
	parameter int ROW_LIMIT   = 4096
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [qgem_pkg::ADDR_BITS-1:0]    paddr,
	input  wire logic [qgem_pkg::DATA_BITS-1:0]    pwdata,
	output logic [qgem_pkg::DATA_BITS-1:0]         prdata,
	output logic                                   pready,
	input  wire logic                              push,
	output logic                                   full,
	input  wire logic [1:0]                        pixel,
	output logic                                   empty,
	input  wire logic                              pop,
	output logic [1:0]                             strength,
	output logic [7:0]                             symbol,
	output logic                                   row_end,
	output logic                                   image_end
);

	localparam int CW = $clog2(LINE_LENGTH);
	localparam int RW = $clog2(ROW_LIMIT);
	localparam int WW = (CW + 1 > qgem_pkg::WIDTH_BITS) ? CW + 1 : qgem_pkg::WIDTH_BITS;
	localparam int HW = (RW + 1 > qgem_pkg::HEIGHT_BITS) ? RW + 1 : qgem_pkg::HEIGHT_BITS;

	logic [qgem_pkg::WIDTH_BITS-1:0]  width_q;
	logic [qgem_pkg::HEIGHT_BITS-1:0] height_q;
	logic [qgem_pkg::LEVEL_BITS-1:0]  levels_q;
	qgem_pkg::reg_index_t             reg_sel;
	logic                             wr_strobe;
	logic [WW-1:0]                    width_ext;
	logic [HW-1:0]                    height_ext;
	logic [WW-1:0]                    wlast_ext;
	logic [HW-1:0]                    hlast_ext;
	logic [CW-1:0]                    wlast;
	logic [RW-1:0]                    hlast;
	logic                             win_valid;
	logic                             win_ready;
	qgem_pkg::window_t                win;
	logic                             q_full;
	logic                             q_valid;
	logic                             q_pop;
	qgem_pkg::window_t                q_data;

	assign pready    = 1'b1;
	assign reg_sel   = qgem_pkg::reg_index_t'(paddr[3:2]);
	assign wr_strobe = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= qgem_pkg::WIDTH_RESET;
			height_q <= qgem_pkg::HEIGHT_RESET;
			levels_q <= qgem_pkg::LEVEL_RESET;
		end else if (wr_strobe) begin
			unique case (reg_sel)
				qgem_pkg::REG_WIDTH:  width_q  <= pwdata[qgem_pkg::WIDTH_BITS-1:0];
				qgem_pkg::REG_HEIGHT: height_q <= pwdata[qgem_pkg::HEIGHT_BITS-1:0];
				qgem_pkg::REG_LEVELS: levels_q <= pwdata[qgem_pkg::LEVEL_BITS-1:0];
				qgem_pkg::REG_NONE: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			qgem_pkg::REG_WIDTH:  prdata = qgem_pkg::DATA_BITS'(width_q);
			qgem_pkg::REG_HEIGHT: prdata = qgem_pkg::DATA_BITS'(height_q);
			qgem_pkg::REG_LEVELS: prdata = qgem_pkg::DATA_BITS'(levels_q);
			qgem_pkg::REG_NONE:   prdata = '0;
		endcase
	end

	always_comb begin
		width_ext  = WW'(width_q);
		height_ext = HW'(height_q);
		if (width_ext == '0) begin
			wlast_ext = '0;
		end else if (width_ext > WW'(LINE_LENGTH)) begin
			wlast_ext = WW'(LINE_LENGTH - 1);
		end else begin
			wlast_ext = width_ext - 1'b1;
		end
		if (height_ext == '0) begin
			hlast_ext = '0;
		end else if (height_ext > HW'(ROW_LIMIT)) begin
			hlast_ext = HW'(ROW_LIMIT - 1);
		end else begin
			hlast_ext = height_ext - 1'b1;
		end
		wlast = wlast_ext[CW-1:0];
		hlast = hlast_ext[RW-1:0];
	end

	assign win_ready = !q_full;

	qgem_front #(
		.LINE_LENGTH(LINE_LENGTH),
		.ROW_LIMIT  (ROW_LIMIT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.pixel    (pixel),
		.wlast    (wlast),
		.hlast    (hlast),
		.win_valid(win_valid),
		.win      (win),
		.win_ready(win_ready)
	);

	qgem_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (win_valid),
		.q_full  (q_full),
		.wr_data (win),
		.rd_valid(q_valid),
		.rd_en   (q_pop),
		.rd_data (q_data)
	);

	qgem_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (q_valid),
		.win        (q_data),
		.in_ready   (q_pop),
		.level_count(levels_q),
		.empty      (empty),
		.pop        (pop),
		.strength   (strength),
		.symbol     (symbol),
		.row_end    (row_end),
		.image_end  (image_end)
	);

endmodule
`default_nettype wire

// ----- rtl/qgem_front.sv -----
`default_nettype none
module qgem_front #(
	parameter int LINE_LENGTH = 128,
	parameter int ROW_LIMIT   = 4096
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           push,
	output logic                                full,
	input  wire logic [1:0]                     pixel,
	input  wire logic [$clog2(LINE_LENGTH)-1:0] wlast,
	input  wire logic [$clog2(ROW_LIMIT)-1:0]   hlast,
	output logic                                win_valid,
	output qgem_pkg::window_t                   win,
	input  wire logic                           win_ready
);

	localparam int CW = $clog2(LINE_LENGTH);
	localparam int RW = $clog2(ROW_LIMIT);

	logic [1:0]    mem [LINE_LENGTH];
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [1:0]    left_q;
	logic [1:0]    upleft_q;
	logic          valid_s1;
	logic          win_s1;
	logic          row_end_s1;
	logic          image_end_s1;
	logic [1:0]    px_s1;
	logic [1:0]    up_s1;
	logic          advance;
	logic          accept;
	logic          last_col;
	logic          last_row;

	assign last_col = col_q >= wlast;
	assign last_row = row_q >= hlast;
	assign advance  = !valid_s1 || !win_s1 || win_ready;
	assign full     = !advance;
	assign accept   = push && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
			left_q   <= '0;
			upleft_q <= '0;
		end else begin
			if (advance) begin
				valid_s1 <= push;
			end
			if (accept) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
			if (valid_s1 && advance) begin
				left_q   <= px_s1;
				upleft_q <= up_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			up_s1        <= mem[col_q];
			mem[col_q]   <= pixel;
			px_s1        <= pixel;
			win_s1       <= (col_q != '0) && (row_q != '0);
			row_end_s1   <= last_col;
			image_end_s1 <= last_col && last_row;
		end
	end

	assign win_valid = valid_s1 && win_s1;

	always_comb begin
		win.p1        = upleft_q;
		win.p2        = up_s1;
		win.p3        = left_q;
		win.p4        = px_s1;
		win.row_end   = row_end_s1;
		win.image_end = image_end_s1;
	end

endmodule
`default_nettype wire

// ----- rtl/qgem_queue.sv -----
`default_nettype none
module qgem_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               wr_en,
	output logic                    q_full,
	input  wire qgem_pkg::window_t  wr_data,
	output logic                    rd_valid,
	input  wire logic               rd_en,
	output qgem_pkg::window_t       rd_data
);

	qgem_pkg::window_t                store [qgem_pkg::QUEUE_DEPTH];
	logic [qgem_pkg::QPTR_BITS-1:0]   wr_ptr_q;
	logic [qgem_pkg::QPTR_BITS-1:0]   rd_ptr_q;
	logic [qgem_pkg::QCNT_BITS-1:0]   count_q;
	logic                             do_wr;
	logic                             do_rd;

	assign q_full   = count_q == qgem_pkg::QCNT_BITS'(qgem_pkg::QUEUE_DEPTH);
	assign rd_valid = count_q != '0;
	assign do_wr    = wr_en && !q_full;
	assign do_rd    = rd_en && rd_valid;
	assign rd_data  = store[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			store[wr_ptr_q] <= wr_data;
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= qgem_pkg::QCNT_BITS'(qgem_pkg::QUEUE_DEPTH))
		else $error("queue count beyond depth");
	a_offer_hold: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && q_full |=> wr_en && $stable(wr_data))
		else $error("item offered to a full queue not held");
`endif

endmodule
`default_nettype wire

// ----- rtl/qgem_back.sv -----
`default_nettype none
module qgem_back (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	input  wire qgem_pkg::window_t               win,
	output logic                                 in_ready,
	input  wire logic [qgem_pkg::LEVEL_BITS-1:0] level_count,
	output logic                                 empty,
	input  wire logic                            pop,
	output logic [1:0]                           strength,
	output logic [7:0]                           symbol,
	output logic                                 row_end,
	output logic                                 image_end
);

	logic [3:0] sum_h;
	logic [3:0] sum_v;
	logic [3:0] abs_h;
	logic [3:0] abs_v;
	logic [2:0] dif_p;
	logic [2:0] dif_n;
	logic [2:0] abs_p;
	logic [2:0] abs_n;
	logic [1:0] g_h;
	logic [1:0] g_v;
	logic [1:0] g_p;
	logic [1:0] g_n;
	logic [1:0] m_a;
	logic [1:0] m_b;
	logic [1:0] m_all;
	logic [7:0] sym;
	logic       out_valid_q;
	logic       load;

	always_comb begin
		sum_h = {2'b00, win.p1} - {2'b00, win.p2} + {2'b00, win.p3} - {2'b00, win.p4};
		sum_v = {2'b00, win.p1} - {2'b00, win.p3} + {2'b00, win.p2} - {2'b00, win.p4};
		abs_h = sum_h[3] ? 4'd0 - sum_h : sum_h;
		abs_v = sum_v[3] ? 4'd0 - sum_v : sum_v;
		dif_p = {1'b0, win.p1} - {1'b0, win.p4};
		dif_n = {1'b0, win.p2} - {1'b0, win.p3};
		abs_p = dif_p[2] ? 3'd0 - dif_p : dif_p;
		abs_n = dif_n[2] ? 3'd0 - dif_n : dif_n;
		g_h   = abs_h[2:1];
		g_v   = abs_v[2:1];
		g_p   = abs_p[1:0];
		g_n   = abs_n[1:0];
		m_a   = (g_v > g_h) ? g_v : g_h;
		m_b   = (g_n > g_p) ? g_n : g_p;
		m_all = (m_b > m_a) ? m_b : m_a;
	end

	always_comb begin
		unique case (level_count)
			qgem_pkg::LEVELS_2: begin
				sym = (m_all == 2'd0) ? qgem_pkg::SYM_SPACE : qgem_pkg::SYM_HASH;
			end
			qgem_pkg::LEVELS_3: begin
				sym = (m_all == 2'd0) ? qgem_pkg::SYM_SPACE :
				      (m_all == 2'd1) ? qgem_pkg::SYM_DOT : qgem_pkg::SYM_HASH;
			end
			qgem_pkg::LEVELS_4: begin
				sym = (m_all == 2'd0) ? qgem_pkg::SYM_SPACE :
				      (m_all == 2'd1) ? qgem_pkg::SYM_DOT :
				      (m_all == 2'd2) ? qgem_pkg::SYM_COLON : qgem_pkg::SYM_HASH;
			end
			default: begin
				sym = qgem_pkg::SYM_NONE;
			end
		endcase
	end

	assign in_ready = !out_valid_q || pop;
	assign load     = in_valid && in_ready;
	assign empty    = !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			strength  <= m_all;
			symbol    <= sym;
			row_end   <= win.row_end;
			image_end <= win.image_end;
		end
	end

`ifndef SYNTH
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !pop |=> out_valid_q)
		else $error("waiting item dropped");
	a_blank_symbol: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && strength == 2'd0 |->
		symbol == qgem_pkg::SYM_SPACE || symbol == qgem_pkg::SYM_NONE)
		else $error("non-blank symbol for zero strength");
`endif

endmodule
`default_nettype wire
